FILE: src/rth_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// Used by every module of the block; depends on nothing.
package rth_pkg;

   // Field widths of one pixel beat and one result beat.
   localparam int COMP_W = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 16;
   localparam int LSUM_W = 9;

   // Both divisions run one restoring step per stage and produce this many quotient bits.
   localparam int DIV_STEPS = 17;
   localparam int QUO_W     = DIV_STEPS;
   localparam int NUM_W     = DIV_STEPS;

   // Hue numerator is (m * 15) << 10, i.e. m * 60 * 256; its divider yields four times the hue.
   localparam int HUE_PROD_W = 15;
   localparam int HUE_HEAD_W = COMP_W;
   localparam int HUE_TAIL_W = HUE_PROD_W - HUE_HEAD_W;
   localparam int HUE_DROP   = QUO_W - HUE_W;

   // Sextant scaled by the difference; at most six times 255.
   localparam int M_W = 11;

   // Front end stages, the division steps and the output register.
   localparam int FRONT_STAGES = 3;
   localparam int PIPE_LAT     = FRONT_STAGES + DIV_STEPS + 1;

   // Largest legal hue code, 360 degrees times 64 less one.
   localparam logic [HUE_W-1:0] HUE_MAX = 15'd23039;

   // Which component is the maximum, red tested first, then green.
   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   // State carried by one beat through the division pipeline.
   typedef struct packed {
      logic                valid;
      logic                grey;
      logic [LSUM_W-1:0]   lsum;
      logic [COMP_W-1:0]   sat_div;
      logic [COMP_W-1:0]   sat_rem;
      logic [NUM_W-1:0]    sat_num;
      logic [QUO_W-1:0]    sat_quo;
      logic [COMP_W-1:0]   hue_div;
      logic [COMP_W-1:0]   hue_rem;
      logic [NUM_W-1:0]    hue_num;
      logic [QUO_W-1:0]    hue_quo;
   } div_stage_type;

endpackage

FILE: src/rth_front.sv
// Front end of the RGB to HSL converter: extremes, sector, difference and divider setup.
// Three register stages; depends on rth_pkg.
module rth_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [rth_pkg::COMP_W-1:0]       in_red,
   input  logic [rth_pkg::COMP_W-1:0]       in_green,
   input  logic [rth_pkg::COMP_W-1:0]       in_blue,
   output rth_pkg::div_stage_type           out_stage
);

   // Stage 1 registers.
   logic                             s1_valid_ff, s1_valid_in;
   logic [rth_pkg::COMP_W-1:0]       s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [rth_pkg::COMP_W-1:0]       s1_max_ff, s1_max_in, s1_min_ff, s1_min_in;
   rth_pkg::sector_type              s1_sector_ff, s1_sector_in;

   // Stage 2 registers.
   logic                             s2_valid_ff;
   logic [rth_pkg::COMP_W-1:0]       s2_diff_ff, s2_diff_in;
   logic [rth_pkg::LSUM_W-1:0]       s2_sum_ff, s2_sum_in;
   logic [rth_pkg::COMP_W-1:0]       s2_den_ff, s2_den_in;
   logic [rth_pkg::M_W-1:0]          s2_m_ff, s2_m_in;

   // Stage 3 register.
   rth_pkg::div_stage_type           s3_ff, s3_in;

   // Stage 2 working values.
   logic [rth_pkg::LSUM_W-1:0]       flip_sum;
   logic [rth_pkg::M_W:0]            m_base, m_wide;
   logic [rth_pkg::M_W:0]            m_plus, m_minus;
   // Stage 3 working value.
   logic [rth_pkg::HUE_PROD_W-1:0]   hue_prod;

   // Largest and smallest component; ties go to red, then green.
   always_comb begin
      s1_valid_in  = in_valid;
      s1_max_in    = in_red;
      s1_min_in    = in_red;
      s1_sector_in = rth_pkg::SECT_RED;
      if (in_green > s1_max_in) begin
         s1_max_in = in_green;
      end
      if (in_blue > s1_max_in) begin
         s1_max_in = in_blue;
      end
      if (in_green < s1_min_in) begin
         s1_min_in = in_green;
      end
      if (in_blue < s1_min_in) begin
         s1_min_in = in_blue;
      end
      if (s1_max_in == in_red) begin
         s1_sector_in = rth_pkg::SECT_RED;
      end else if (s1_max_in == in_green) begin
         s1_sector_in = rth_pkg::SECT_GREEN;
      end else begin
         s1_sector_in = rth_pkg::SECT_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_red_ff    <= in_red;
      s1_green_ff  <= in_green;
      s1_blue_ff   <= in_blue;
      s1_max_ff    <= s1_max_in;
      s1_min_ff    <= s1_min_in;
      s1_sector_ff <= s1_sector_in;
   end

   // Difference, lightness sum, saturation denominator and the hue sextant times d.
   always_comb begin
      s2_diff_in = s1_max_ff - s1_min_ff;
      s2_sum_in  = {1'b0, s1_max_ff} + {1'b0, s1_min_ff};
      flip_sum   = 9'd510 - s2_sum_in;
      if (s2_sum_in <= 9'd255) begin
         s2_den_in = s2_sum_in[rth_pkg::COMP_W-1:0];
      end else begin
         s2_den_in = flip_sum[rth_pkg::COMP_W-1:0];
      end
      case (s1_sector_ff)
         rth_pkg::SECT_RED: begin
            // A negative red sextant wraps by six sextants.
            if (s1_green_ff >= s1_blue_ff) begin
               m_base = '0;
            end else begin
               m_base = {2'b00, s2_diff_in, 2'b00} + {3'b000, s2_diff_in, 1'b0};
            end
            m_plus  = {4'b0000, s1_green_ff};
            m_minus = {4'b0000, s1_blue_ff};
         end
         rth_pkg::SECT_GREEN: begin
            m_base  = {3'b000, s2_diff_in, 1'b0};
            m_plus  = {4'b0000, s1_blue_ff};
            m_minus = {4'b0000, s1_red_ff};
         end
         default: begin
            m_base  = {2'b00, s2_diff_in, 2'b00};
            m_plus  = {4'b0000, s1_red_ff};
            m_minus = {4'b0000, s1_green_ff};
         end
      endcase
      m_wide  = m_base + m_plus - m_minus;
      s2_m_in = m_wide[rth_pkg::M_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_diff_ff <= s2_diff_in;
      s2_sum_ff  <= s2_sum_in;
      s2_den_ff  <= s2_den_in;
      s2_m_ff    <= s2_m_in;
   end

   // Scale the hue numerator by fifteen and load both dividers.
   always_comb begin
      hue_prod      = {s2_m_ff, 4'b0000} - {4'b0000, s2_m_ff};
      s3_in.valid   = s2_valid_ff;
      s3_in.grey    = (s2_diff_ff == '0);
      s3_in.lsum    = s2_sum_ff;
      s3_in.sat_div = s2_den_ff;
      s3_in.sat_rem = {1'b0, s2_diff_ff[rth_pkg::COMP_W-1:1]};
      s3_in.sat_num = {s2_diff_ff[0], {(rth_pkg::NUM_W-1){1'b0}}};
      s3_in.sat_quo = '0;
      s3_in.hue_div = s2_diff_ff;
      s3_in.hue_rem = hue_prod[rth_pkg::HUE_PROD_W-1:rth_pkg::HUE_TAIL_W];
      s3_in.hue_num = {hue_prod[rth_pkg::HUE_TAIL_W-1:0],
                       {(rth_pkg::NUM_W-rth_pkg::HUE_TAIL_W){1'b0}}};
      s3_in.hue_quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else begin
         s3_ff <= s3_in;
      end
   end

   assign out_stage = s3_ff;

endmodule

FILE: src/rth_div_step.sv
// One registered restoring division step for both the saturation and the hue quotient.
// Depends on rth_pkg.
module rth_div_step (
   input  logic                     clock,
   input  logic                     reset,
   input  rth_pkg::div_stage_type   in_stage,
   output rth_pkg::div_stage_type   out_stage
);

   rth_pkg::div_stage_type          stage_ff, stage_in;
   logic [rth_pkg::COMP_W:0]        sat_trial, hue_trial;
   logic [rth_pkg::COMP_W:0]        sat_diff, hue_diff;
   logic                            sat_ge, hue_ge;

   // Bring down the next numerator bit and subtract the divisor when it fits.
   always_comb begin
      stage_in  = in_stage;
      sat_trial = {in_stage.sat_rem, in_stage.sat_num[rth_pkg::NUM_W-1]};
      hue_trial = {in_stage.hue_rem, in_stage.hue_num[rth_pkg::NUM_W-1]};
      sat_ge    = (sat_trial >= {1'b0, in_stage.sat_div});
      hue_ge    = (hue_trial >= {1'b0, in_stage.hue_div});
      sat_diff  = sat_ge ? (sat_trial - {1'b0, in_stage.sat_div}) : sat_trial;
      hue_diff  = hue_ge ? (hue_trial - {1'b0, in_stage.hue_div}) : hue_trial;
      // The remainder stays below the divisor, so eight bits hold it.
      stage_in.sat_rem = sat_diff[rth_pkg::COMP_W-1:0];
      stage_in.hue_rem = hue_diff[rth_pkg::COMP_W-1:0];
      stage_in.sat_num = {in_stage.sat_num[rth_pkg::NUM_W-2:0], 1'b0};
      stage_in.hue_num = {in_stage.hue_num[rth_pkg::NUM_W-2:0], 1'b0};
      stage_in.sat_quo = {in_stage.sat_quo[rth_pkg::QUO_W-2:0], sat_ge};
      stage_in.hue_quo = {in_stage.hue_quo[rth_pkg::QUO_W-2:0], hue_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

FILE: src/rgb_to_hsl_core.sv
// Top level of the pipelined RGB to HSL converter.
// Depends on rth_pkg, rth_front and rth_div_step.
//
//   Channel   Ports                                   Handshake
//   request   req_red, req_green, req_blue            start high while busy low
//   response  rsp_hue, rsp_saturation,                rsp_valid for one cycle
//             rsp_lightness_sum
//
// One pixel is taken every clock cycle; busy is never raised.
// Each result passes through three front end stages,
// seventeen restoring division steps (one quotient bit each) and the output register.
// Synchronous reset clears every valid bit, dropping beats in flight.
// The receiver cannot stall, so results leave on a fixed schedule.
module rgb_to_hsl_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rth_pkg::COMP_W-1:0]        req_red,
   input  logic [rth_pkg::COMP_W-1:0]        req_green,
   input  logic [rth_pkg::COMP_W-1:0]        req_blue,
   output logic                              rsp_valid,
   output logic [rth_pkg::HUE_W-1:0]         rsp_hue,
   output logic [rth_pkg::SAT_W-1:0]         rsp_saturation,
   output logic [rth_pkg::LSUM_W-1:0]        rsp_lightness_sum
);

   rth_pkg::div_stage_type            div_pipe [0:rth_pkg::DIV_STEPS];
   logic                              rsp_valid_ff;
   logic [rth_pkg::HUE_W-1:0]         rsp_hue_ff, rsp_hue_in;
   logic [rth_pkg::SAT_W-1:0]         rsp_sat_ff, rsp_sat_in;
   logic [rth_pkg::LSUM_W-1:0]        rsp_lsum_ff;
   rth_pkg::div_stage_type            last_stage;

   // The pipeline takes a beat every cycle.
   assign busy = 1'b0;

   rth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_stage (div_pipe[0])
   );

   // Chain of division steps.
   for (genvar i = 0; i < rth_pkg::DIV_STEPS; i++) begin : g_step
      rth_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (div_pipe[i]),
         .out_stage (div_pipe[i+1])
      );
   end

   // Grey pixels give zero hue and saturation; a ratio of one saturates.
   always_comb begin
      last_stage = div_pipe[rth_pkg::DIV_STEPS];
      if (last_stage.grey) begin
         rsp_hue_in = '0;
         rsp_sat_in = '0;
      end else begin
         rsp_hue_in = last_stage.hue_quo[rth_pkg::QUO_W-1:rth_pkg::HUE_DROP];
         if (last_stage.sat_quo[rth_pkg::QUO_W-1]) begin
            rsp_sat_in = '1;
         end else begin
            rsp_sat_in = last_stage.sat_quo[rth_pkg::SAT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last_stage.valid;
      end
      rsp_hue_ff  <= rsp_hue_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_lsum_ff <= last_stage.lsum;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hue           = rsp_hue_ff;
   assign rsp_saturation    = rsp_sat_ff;
   assign rsp_lightness_sum = rsp_lsum_ff;

endmodule

FILE: src/rth_checker.sv
// Port level checks for rgb_to_hsl_core, attached by the bind statement at the end.
// Depends on rth_pkg and the top level's ports.
module rth_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [rth_pkg::COMP_W-1:0]        req_red,
   input  logic [rth_pkg::COMP_W-1:0]        req_green,
   input  logic [rth_pkg::COMP_W-1:0]        req_blue,
   input  logic                              rsp_valid,
   input  logic [rth_pkg::HUE_W-1:0]         rsp_hue,
   input  logic [rth_pkg::SAT_W-1:0]         rsp_saturation,
   input  logic [rth_pkg::LSUM_W-1:0]        rsp_lightness_sum
);

   // Every accepted beat yields a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(rth_pkg::PIPE_LAT) rsp_valid)
      else $error("accepted beat gave no result");

   // No result appears without a beat taken at the matching cycle.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##(rth_pkg::PIPE_LAT) !rsp_valid)
      else $error("result without an accepted beat");

   // A grey pixel gives zero hue and saturation and twice its level as lightness.
   a_grey_pixel: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_red == req_green && req_green == req_blue)
      |-> ##(rth_pkg::PIPE_LAT)
      (rsp_hue == '0 && rsp_saturation == '0
       && rsp_lightness_sum == {$past(req_red, rth_pkg::PIPE_LAT), 1'b0}))
      else $error("grey pixel converted wrongly");

   // Hue stays below 360 degrees.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue <= rth_pkg::HUE_MAX))
      else $error("hue out of range");

endmodule

bind rgb_to_hsl_core rth_checker u_rth_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for rgb_to_hsl_core: pixel beats go in, hue, saturation and lightness come out.
// Depends on rth_pkg for field widths; the expected colour values are worked out here.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // Hue fraction bits of the block as built, and run bounds.
   localparam int HUE_FRAC    = 6;
   localparam int SETTLE      = 32;
   localparam int CYCLE_LIMIT = 600000;

   // One expected result beat.
   typedef struct packed {
      logic [rth_pkg::HUE_W-1:0]  hue;
      logic [rth_pkg::SAT_W-1:0]  sat;
      logic [rth_pkg::LSUM_W-1:0] lsum;
   } hsl_beat_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [rth_pkg::COMP_W-1:0] req_red;
   logic [rth_pkg::COMP_W-1:0] req_green;
   logic [rth_pkg::COMP_W-1:0] req_blue;
   logic                       rsp_valid;
   logic [rth_pkg::HUE_W-1:0]  rsp_hue;
   logic [rth_pkg::SAT_W-1:0]  rsp_saturation;
   logic [rth_pkg::LSUM_W-1:0] rsp_lightness_sum;

   hsl_beat_type pending_hsl[$];
   int           mismatch_count = 0;
   int           pixels_sent    = 0;
   int           greys_sent     = 0;
   int           results_seen   = 0;
   int           cycle_count    = 0;
   bit           gaps_enabled   = 1'b1;

   rgb_to_hsl_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_hue           (rsp_hue),
      .rsp_saturation    (rsp_saturation),
      .rsp_lightness_sum (rsp_lightness_sum)
   );

   // Free-running 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact integer conversion of one pixel to its hue, saturation and lightness sum.
   function automatic hsl_beat_type hsl_of_pixel(input logic [rth_pkg::COMP_W-1:0] r,
                                                 input logic [rth_pkg::COMP_W-1:0] g,
                                                 input logic [rth_pkg::COMP_W-1:0] b);
      int unsigned  hi, lo, span, total, denom, sextant, sat_q, hue_q;
      hsl_beat_type res;
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      total    = hi + lo;
      res.lsum = total[rth_pkg::LSUM_W-1:0];
      // A grey pixel has neither hue nor saturation.
      if (hi == lo) begin
         res.hue = '0;
         res.sat = '0;
         return res;
      end
      span  = hi - lo;
      denom = (total <= 255) ? total : 510 - total;
      sat_q = (span << 16) / denom;
      if (sat_q > 65535) sat_q = 65535;
      // Position within the colour wheel scaled by the span; red wins ties, then green.
      if (hi == r) begin
         sextant = (g >= b) ? g - b : 6 * span - (b - g);
      end else if (hi == g) begin
         sextant = 2 * span + b - r;
      end else begin
         sextant = 4 * span + r - g;
      end
      hue_q   = ((sextant * 60) << HUE_FRAC) / span;
      res.hue = hue_q[rth_pkg::HUE_W-1:0];
      res.sat = sat_q[rth_pkg::SAT_W-1:0];
      return res;
   endfunction

   // One random component level.
   function automatic logic [rth_pkg::COMP_W-1:0] rand_level();
      int unsigned v;
      v = $urandom_range(0, 255);
      return v[rth_pkg::COMP_W-1:0];
   endfunction

   // Idle length after a beat: mostly none or short, now and then long.
   function automatic int idle_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!gaps_enabled || p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Present one pixel, hold it until taken, record its expected result, then idle a while.
   task automatic send_pixel(input logic [rth_pkg::COMP_W-1:0] r,
                             input logic [rth_pkg::COMP_W-1:0] g,
                             input logic [rth_pkg::COMP_W-1:0] b);
      int gap;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      start     <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_hsl.push_back(hsl_of_pixel(r, g, b));
      pixels_sent++;
      if (r == g && g == b) greys_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending, wait for every expected beat, then let the pipeline settle.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_hsl.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Corners of the colour cube, sector ties, the hue wrap and the saturation boundary.
   task automatic test_directed();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd200, 8'd10,  8'd199);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd127, 8'd127);
      send_pixel(8'd128, 8'd128, 8'd127);
      send_pixel(8'd129, 8'd127, 8'd127);
      send_pixel(8'd100, 8'd50,  8'd0);
      send_pixel(8'd170, 8'd85,  8'd255);
      send_pixel(8'd85,  8'd170, 8'd85);
      send_pixel(8'd64,  8'd32,  8'd255);
      drain_results();
   endtask

   // Uniformly random pixels with random idling.
   task automatic test_random_pixels(input int count);
      repeat (count) begin
         send_pixel(rand_level(), rand_level(), rand_level());
      end
      drain_results();
   endtask

   // Nearly grey pixels: tiny spans, ties and the mid-lightness boundary.
   task automatic test_near_grey(input int count);
      int base, c0, c1, c2;
      repeat (count) begin
         base = ($urandom_range(0, 1) == 1) ? $urandom_range(124, 131) : $urandom_range(0, 255);
         c0 = base + $urandom_range(0, 3) - 1;
         c1 = base + $urandom_range(0, 3) - 1;
         c2 = base + $urandom_range(0, 3) - 1;
         if (c0 < 0) c0 = 0;
         if (c1 < 0) c1 = 0;
         if (c2 < 0) c2 = 0;
         if (c0 > 255) c0 = 255;
         if (c1 > 255) c1 = 255;
         if (c2 > 255) c2 = 255;
         send_pixel(c0[rth_pkg::COMP_W-1:0], c1[rth_pkg::COMP_W-1:0],
                    c2[rth_pkg::COMP_W-1:0]);
      end
      drain_results();
   endtask

   // Back-to-back beats with no idling, components drawn from edge values.
   task automatic test_back_to_back(input int count);
      logic [rth_pkg::COMP_W-1:0] edges[9];
      edges = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd129, 8'd253, 8'd254, 8'd255};
      gaps_enabled = 1'b0;
      repeat (count) begin
         send_pixel(edges[$urandom_range(0, 8)], edges[$urandom_range(0, 8)],
                    edges[$urandom_range(0, 8)]);
      end
      gaps_enabled = 1'b1;
      drain_results();
   endtask

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      hsl_beat_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            results_seen++;
            if (pending_hsl.size() == 0) begin
               $error("result beat with nothing expected: hue %0d sat %0d lsum %0d",
                      rsp_hue, rsp_saturation, rsp_lightness_sum);
               mismatch_count++;
            end else begin
               want = pending_hsl.pop_front();
               if (rsp_hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, rsp_hue);
                  mismatch_count++;
               end
               if (rsp_saturation !== want.sat) begin
                  $error("saturation: expected %0d, got %0d", want.sat, rsp_saturation);
                  mismatch_count++;
               end
               if (rsp_lightness_sum !== want.lsum) begin
                  $error("lightness_sum: expected %0d, got %0d", want.lsum, rsp_lightness_sum);
                  mismatch_count++;
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            $error("rsp_valid: expected 0 or 1, got %b", rsp_valid);
            mismatch_count++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Reset, run each test in turn, then report.
   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_pixels(1000);
      test_near_grey(400);
      test_back_to_back(300);

      if (pending_hsl.size() != 0) begin
         $error("%0d expected result beats never arrived", pending_hsl.size());
         mismatch_count++;
      end
      $display("Sent %0d pixel beats (%0d grey), checked %0d result beats, %0d mismatches.",
               pixels_sent, greys_sent, results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
